FILE: hw/rtl/mersenne_twister_generator_top_macros.svh
// assertion macros for the twister generator checker
// no dependencies; taken in by the checker file
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_MACROS_SVH

// clocked assertion, masked while reset is high
`define MTG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define MTG_ASSERT_CR(lbl, prop, msg) \
   `MTG_ASSERT(lbl, clock, reset, prop, msg)

`endif

FILE: hw/rtl/mtg_pkg.sv
// shared constants, item types and helpers for the twister generator
// no dependencies
`timescale 1ns / 1ps
package mtg_pkg;

   localparam int STATE_WORDS = 624;
   localparam int TAP_OFFSET  = 397;
   localparam int KEY_DEPTH   = 64;

   localparam int SW_AW     = $clog2(STATE_WORDS);
   localparam int IDX_W     = $clog2(STATE_WORDS + 1);
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int KEY_CNT_W = $clog2(KEY_DEPTH + 1);
   localparam int PASS1_MAX = (KEY_DEPTH > STATE_WORDS) ? KEY_DEPTH : STATE_WORDS;
   localparam int CNT_W     = $clog2(PASS1_MAX + 1);

   localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
   localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
   localparam logic [31:0] ARRAY_SEED   = 32'd19650218;
   localparam logic [31:0] MUL_PASS1    = 32'd1664525;
   localparam logic [31:0] MUL_PASS2    = 32'd1566083941;
   localparam logic [31:0] MUL_SEED     = 32'd1812433253;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [31:0] DEFAULT_SEED = 32'd5489;

   localparam logic [1:0] REQ_RESEED = 2'd0;
   localparam logic [1:0] REQ_KEY    = 2'd1;
   localparam logic [1:0] REQ_DRAW   = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] seed_word;
      logic        key_last;
   } req_item_type;

   typedef struct packed {
      logic [31:0] random_word;
      logic        auto_seeded;
   } rsp_item_type;

   // fold used by every seeding recurrence
   function automatic logic [31:0] mix30(input logic [31:0] p);
      return p ^ (p >> 30);
   endfunction

endpackage

FILE: hw/rtl/mersenne_twister_generator_top.sv
// twister generator top: sequencer around the state and key rams
// depends on mtg_pkg, mtg_ram, mtg_temper
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_item_type
//  rsp     | out       | rsp_valid/rsp_stall | rsp_item_type
//  csr     | in        | csr_valid/csr_ready | default_seed word
//
// a draw with words left reads the state ram and then waits for the output; an exhausted index
// first adds a regeneration, set by one state-ram read port (per word: read next word, read tap, write)
// reseed writes word 0 direct, then a multiply and a write per word; the last key word adds
// two more passes of a multiply and a write per word, and a closing write of word 0
// synchronous reset clears control only; ram contents stay undefined until written
// an item is taken whenever the sequencer is idle, even while a result waits
`timescale 1ns / 1ps
module mersenne_twister_generator_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mtg_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mtg_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);
   import mtg_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SEED      = 4'd1;
   localparam logic [3:0] ST_ARR1      = 4'd2;
   localparam logic [3:0] ST_ARR2      = 4'd3;
   localparam logic [3:0] ST_ARR_FIN   = 4'd4;
   localparam logic [3:0] ST_REGEN_PRE = 4'd5;
   localparam logic [3:0] ST_REGEN_LD  = 4'd6;
   localparam logic [3:0] ST_REGEN     = 4'd7;
   localparam logic [3:0] ST_DRAW_RD   = 4'd8;
   localparam logic [3:0] ST_DRAW_OUT  = 4'd9;

   // what follows a single-word seed
   localparam logic [1:0] GOAL_NONE = 2'd0;
   localparam logic [1:0] GOAL_ARR  = 2'd1;
   localparam logic [1:0] GOAL_DRAW = 2'd2;

   localparam logic [SW_AW-1:0] LAST_WORD = SW_AW'(STATE_WORDS - 1);
   localparam logic [SW_AW-1:0] TAP_WRAP  = SW_AW'(STATE_WORDS - TAP_OFFSET);

   logic [3:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           goal_ff, goal_in;
   logic [SW_AW-1:0]     n_ff, n_in;         // word position / step
   logic [KEY_AW-1:0]    kpos_ff, kpos_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [KEY_CNT_W-1:0] len_ff, len_in;
   logic [KEY_CNT_W-1:0] key_count_ff, key_count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 seeded_ff, seeded_in;
   logic                 autos_ff, autos_in;
   logic [31:0]          dflt_ff, dflt_in;
   logic [31:0]          p_ff, p_in;         // previous word of the recurrence
   logic [31:0]          cur_ff, cur_in;     // old value of word k during regeneration
   logic [31:0]          nb_ff, nb_in;       // old value of word k+1
   logic [31:0]          mul_ff, mul_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   // state ram ports
   logic             s_we;
   logic [SW_AW-1:0] s_waddr, s_raddr;
   logic [31:0]      s_wdata, s_rdata;
   // key ram ports
   logic              k_we;
   logic [KEY_AW-1:0] k_waddr, k_raddr;
   logic [31:0]       k_rdata;

   logic [31:0]          mul_const;
   logic [31:0]          tempered;
   logic [31:0]          new_word;
   logic [31:0]          y_mix;
   logic [KEY_CNT_W-1:0] kc_next;
   logic [KEY_CNT_W-1:0] kpos_inc;
   logic                 key_room;
   logic                 req_take;
   logic                 out_free;

   mtg_ram #(.DEPTH(STATE_WORDS), .WIDTH(32)) u_state_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   mtg_ram #(.DEPTH(KEY_DEPTH), .WIDTH(32)) u_key_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (req_item.seed_word),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   mtg_temper u_temper (
      .word     (s_rdata),
      .tempered (tempered)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   // one shared multiplier, constant picked by the running pass
   always_comb begin
      case (state_ff)
         ST_ARR1: mul_const = MUL_PASS1;
         ST_ARR2: mul_const = MUL_PASS2;
         default: mul_const = MUL_SEED;
      endcase
      mul_in = 32'(mix30(p_ff) * mul_const);
   end

   assign key_room = (key_count_ff < KEY_CNT_W'(KEY_DEPTH));
   assign kc_next  = key_count_ff + KEY_CNT_W'(key_room);
   assign kpos_inc = KEY_CNT_W'(kpos_ff) + KEY_CNT_W'(1);
   assign y_mix    = {cur_ff[31], nb_ff[30:0]};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      goal_in      = goal_ff;
      n_in         = n_ff;
      kpos_in      = kpos_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      key_count_in = key_count_ff;
      idx_in       = idx_ff;
      seeded_in    = seeded_ff;
      autos_in     = autos_ff;
      dflt_in      = dflt_ff;
      p_in         = p_ff;
      cur_in       = cur_ff;
      nb_in        = nb_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      s_we         = 1'b0;
      s_waddr      = n_ff;
      s_wdata      = 32'd0;
      s_raddr      = n_ff;
      k_we         = 1'b0;
      k_waddr      = key_count_ff[KEY_AW-1:0];
      k_raddr      = kpos_ff;
      new_word     = 32'd0;

      if (csr_valid && csr_ready) begin
         dflt_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_item.req_type)
                  REQ_RESEED: begin
                     p_in     = req_item.seed_word;
                     n_in     = '0;
                     phase_in = 2'd1;
                     goal_in  = GOAL_NONE;
                     state_in = ST_SEED;
                  end
                  REQ_KEY: begin
                     k_we         = key_room;
                     key_count_in = kc_next;
                     if (req_item.key_last) begin
                        key_count_in = '0;
                        if (kc_next != '0) begin
                           len_in   = kc_next;
                           p_in     = ARRAY_SEED;
                           n_in     = '0;
                           phase_in = 2'd1;
                           goal_in  = GOAL_ARR;
                           state_in = ST_SEED;
                        end
                     end
                  end
                  REQ_DRAW: begin
                     autos_in = !seeded_ff;
                     if (!seeded_ff) begin
                        p_in     = dflt_ff;
                        n_in     = '0;
                        phase_in = 2'd1;
                        goal_in  = GOAL_DRAW;
                        state_in = ST_SEED;
                     end else if (idx_ff >= IDX_W'(STATE_WORDS)) begin
                        state_in = ST_REGEN_PRE;
                     end else begin
                        state_in = ST_DRAW_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SEED: begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else begin
               new_word = (n_ff == '0) ? p_ff : mul_ff + 32'(n_ff);
               s_we     = 1'b1;
               s_wdata  = new_word;
               p_in     = new_word;
               phase_in = 2'd0;
               n_in     = n_ff + SW_AW'(1);
               if (n_ff == LAST_WORD) begin
                  idx_in    = IDX_W'(STATE_WORDS);
                  seeded_in = 1'b1;
                  case (goal_ff)
                     GOAL_ARR: begin
                        n_in     = SW_AW'(1);
                        kpos_in  = '0;
                        p_in     = ARRAY_SEED;
                        cnt_in   = (CNT_W'(len_ff) > CNT_W'(STATE_WORDS)) ?
                                   CNT_W'(len_ff) : CNT_W'(STATE_WORDS);
                        state_in = ST_ARR1;
                     end
                     GOAL_DRAW: state_in = ST_REGEN_PRE;
                     default:   state_in = ST_IDLE;
                  endcase
               end
            end
         end

         ST_ARR1, ST_ARR2: begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else begin
               if (state_ff == ST_ARR1) begin
                  new_word = (s_rdata ^ mul_ff) + k_rdata + 32'(kpos_ff);
               end else begin
                  new_word = (s_rdata ^ mul_ff) - 32'(n_ff);
               end
               s_we     = 1'b1;
               s_wdata  = new_word;
               p_in     = new_word;
               phase_in = 2'd0;
               n_in     = (n_ff == LAST_WORD) ? SW_AW'(1) : n_ff + SW_AW'(1);
               kpos_in  = (kpos_inc >= len_ff) ? '0 : KEY_AW'(kpos_inc);
               cnt_in   = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  if (state_ff == ST_ARR1) begin
                     cnt_in   = CNT_W'(STATE_WORDS - 1);
                     state_in = ST_ARR2;
                  end else begin
                     state_in = ST_ARR_FIN;
                  end
               end
            end
         end

         ST_ARR_FIN: begin
            s_we      = 1'b1;
            s_waddr   = '0;
            s_wdata   = MT_UPPER;
            idx_in    = IDX_W'(STATE_WORDS);
            seeded_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_REGEN_PRE: begin
            s_raddr  = '0;
            n_in     = '0;
            state_in = ST_REGEN_LD;
         end

         ST_REGEN_LD: begin
            cur_in   = s_rdata;
            phase_in = 2'd0;
            state_in = ST_REGEN;
         end

         ST_REGEN: begin
            case (phase_ff)
               2'd0: begin
                  s_raddr  = (n_ff == LAST_WORD) ? '0 : n_ff + SW_AW'(1);
                  phase_in = 2'd1;
               end
               2'd1: begin
                  nb_in    = s_rdata;
                  s_raddr  = (n_ff < TAP_WRAP) ? n_ff + SW_AW'(TAP_OFFSET) : n_ff - TAP_WRAP;
                  phase_in = 2'd2;
               end
               default: begin
                  s_we     = 1'b1;
                  s_wdata  = s_rdata ^ (y_mix >> 1) ^ (y_mix[0] ? MT_MATRIX : 32'd0);
                  cur_in   = nb_ff;
                  phase_in = 2'd0;
                  n_in     = n_ff + SW_AW'(1);
                  if (n_ff == LAST_WORD) begin
                     idx_in   = '0;
                     state_in = ST_DRAW_RD;
                  end
               end
            endcase
         end

         ST_DRAW_RD: begin
            s_raddr  = SW_AW'(idx_ff);
            state_in = ST_DRAW_OUT;
         end

         ST_DRAW_OUT: begin
            // hold the address so the read data stays while the output is busy
            s_raddr = SW_AW'(idx_ff);
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.random_word = tempered;
               rsp_item_in.auto_seeded = autos_ff;
               idx_in                  = idx_ff + IDX_W'(1);
               state_in                = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         goal_ff      <= GOAL_NONE;
         key_count_ff <= '0;
         idx_ff       <= '0;
         seeded_ff    <= 1'b0;
         autos_ff     <= 1'b0;
         dflt_ff      <= DEFAULT_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         goal_ff      <= goal_in;
         key_count_ff <= key_count_in;
         idx_ff       <= idx_in;
         seeded_ff    <= seeded_in;
         autos_ff     <= autos_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      kpos_ff     <= kpos_in;
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      p_ff        <= p_in;
      cur_ff      <= cur_in;
      nb_ff       <= nb_in;
      mul_ff      <= mul_in;
      rsp_item_ff <= rsp_item_in;
   end
endmodule

FILE: hw/rtl/mtg_ram.sv
// generic one-write one-read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps
module mtg_ram #(
   parameter int DEPTH = 624,
   parameter int WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hw/rtl/mtg_temper.sv
// output tempering of one state word
// depends on mtg_pkg
`timescale 1ns / 1ps
module mtg_temper (
   input  logic [31:0] word,
   output logic [31:0] tempered
);
   import mtg_pkg::*;

   logic [31:0] t1, t2, t3;

   always_comb begin
      t1 = word ^ (word >> 11);
      t2 = t1 ^ ((t1 << 7) & TEMPER_B);
      t3 = t2 ^ ((t2 << 15) & TEMPER_C);
      tempered = t3 ^ (t3 >> 18);
   end
endmodule

FILE: hw/rtl/mtg_checker.sv
// port-level checker for the twister generator, bound to the top level
// depends on mtg_pkg and the macros header
`timescale 1ns / 1ps
`include "mersenne_twister_generator_top_macros.svh"
module mtg_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input mtg_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input mtg_pkg::rsp_item_type rsp_item,
   input logic                  csr_valid,
   input logic                  csr_ready
);
   import mtg_pkg::*;

   // a held item stays until taken
   `MTG_ASSERT_CR(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "rsp item changed while stalled")

   // an accepted draw always leaves the sequencer busy in the next cycle
   `MTG_ASSERT_CR(a_busy_after_draw, req_valid && !req_stall && req_item.req_type == REQ_DRAW |=> req_stall, "draw accepted without going busy")

   // a new item only appears after the sequencer was busy reading it
   `MTG_ASSERT_CR(a_rsp_from_busy, $rose(rsp_valid) |-> $past(req_stall), "item appeared without a busy cycle")

   // configuration writes are never refused
   `MTG_ASSERT_CR(a_csr_ready, csr_valid |-> csr_ready, "csr write refused")
endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (.*);

FILE: dv/mersenne_twister_generator_top_tb.sv
// testbench for the twister generator top: directed and random requests with a scoreboard
// depends on mtg_pkg and mersenne_twister_generator_top
`timescale 1ns / 1ps
module mersenne_twister_generator_top_tb;
   import mtg_pkg::*;

   // generous cycle limit, far above the slowest legal run
   localparam int unsigned CYCLE_LIMIT = 20000000;
   // longest quiet spell of the block: seeding plus array passes plus regeneration
   localparam int unsigned SETTLE_CYCLES = 7000;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // keeps a software copy of the generator and the draws still owed
   class twister_scoreboard;
      bit [31:0] words [STATE_WORDS];
      bit [31:0] keys [KEY_DEPTH];
      int unsigned read_pos;
      int unsigned key_fill;
      bit has_seed;
      bit [31:0] boot_seed;
      rsp_item_type draws_due [$];
      int unsigned mismatches;

      function new();
         read_pos = 0;
         key_fill = 0;
         has_seed = 0;
         boot_seed = DEFAULT_SEED;
         mismatches = 0;
      endfunction

      function void set_boot_seed(bit [31:0] v);
         boot_seed = v;
      endfunction

      function void load_seed(bit [31:0] s);
         bit [31:0] p;
         words[0] = s;
         for (int n = 1; n < STATE_WORDS; n++) begin
            p = words[n-1];
            words[n] = MUL_SEED * (p ^ (p >> 30)) + n;
         end
         read_pos = STATE_WORDS;
         has_seed = 1;
      endfunction

      function void load_key(int unsigned len);
         int unsigned pos, kpos, n;
         bit [31:0] p;
         pos = 1;
         kpos = 0;
         load_seed(ARRAY_SEED);
         n = (len > STATE_WORDS) ? len : STATE_WORDS;
         for (; n > 0; n--) begin
            p = words[pos-1];
            words[pos] = (words[pos] ^ ((p ^ (p >> 30)) * MUL_PASS1)) + keys[kpos] + kpos;
            pos++;
            kpos++;
            if (pos >= STATE_WORDS) begin
               words[0] = words[STATE_WORDS-1];
               pos = 1;
            end
            if (kpos >= len) kpos = 0;
         end
         for (n = STATE_WORDS - 1; n > 0; n--) begin
            p = words[pos-1];
            words[pos] = (words[pos] ^ ((p ^ (p >> 30)) * MUL_PASS2)) - pos;
            pos++;
            if (pos >= STATE_WORDS) begin
               words[0] = words[STATE_WORDS-1];
               pos = 1;
            end
         end
         words[0] = MT_UPPER;
         read_pos = STATE_WORDS;
         has_seed = 1;
      endfunction

      function void twist_all();
         int unsigned nxt, tap;
         bit [31:0] y;
         for (int unsigned k = 0; k < STATE_WORDS; k++) begin
            nxt = (k + 1) % STATE_WORDS;
            tap = (k + TAP_OFFSET) % STATE_WORDS;
            y = (words[k] & MT_UPPER) | (words[nxt] & ~MT_UPPER);
            words[k] = words[tap] ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
         end
         read_pos = 0;
      endfunction

      // accepted request: update the model, queue a draw result if one is due
      function void note_request(req_item_type it);
         rsp_item_type r;
         bit [31:0] y;
         case (it.req_type)
            REQ_RESEED: load_seed(it.seed_word);
            REQ_KEY: begin
               if (key_fill < KEY_DEPTH) begin
                  keys[key_fill] = it.seed_word;
                  key_fill++;
               end
               if (it.key_last) begin
                  if (key_fill > 0) load_key(key_fill);
                  key_fill = 0;
               end
            end
            REQ_DRAW: begin
               r.auto_seeded = !has_seed;
               if (!has_seed) load_seed(boot_seed);
               if (read_pos >= STATE_WORDS) twist_all();
               y = words[read_pos];
               read_pos++;
               y ^= y >> 11;
               y ^= (y << 7) & TEMPER_B;
               y ^= (y << 15) & TEMPER_C;
               y ^= y >> 18;
               r.random_word = y;
               draws_due.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_draw(rsp_item_type got);
         rsp_item_type want;
         if (draws_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: word %h auto %b", got.random_word, got.auto_seeded);
            return;
         end
         want = draws_due.pop_front();
         if (got.random_word !== want.random_word || got.auto_seeded !== want.auto_seeded) begin
            mismatches++;
            if (mismatches <= 10)
               $display("draw mismatch: expected word %h auto %b, got word %h auto %b",
                        want.random_word, want.auto_seeded, got.random_word, got.auto_seeded);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   twister_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;

   mersenne_twister_generator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watch both channels at the edge; values seen here are the pre-edge ones
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && !req_stall) sb.note_request(req_item);
      if (!reset && rsp_valid && !rsp_stall) sb.check_draw(rsp_item);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mersenne_twister_generator_top_tb: errors");
         $finish;
      end
   end

   // receiver stall: quiet windows alternate with light, heavy and half-rate stalling
   always @(posedge clock) begin
      case (cycle_count[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // hand one item over; bursts of random length, mostly with gaps between them
   task automatic send_item(logic [1:0] kind, logic [31:0] word, logic last);
      if (burst_left == 0) begin
         int unsigned gap;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_item  <= '{req_type: kind, seed_word: word, key_last: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic send_key_run(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_item(REQ_KEY, $urandom, i == len - 1);
   endtask

   // wait for all draws, then let any seeding or array pass run out
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.draws_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_boot_seed(logic [31:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_boot_seed(v);
   endtask

   task automatic random_phase(int unsigned count, bit with_full_key);
      int unsigned stop_at, pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (with_full_key && items_sent == stop_at - count / 2) begin
            // overflow the key buffer; the last word still triggers the array pass
            send_key_run(KEY_DEPTH + $urandom_range(1, 6));
         end else if (pick < 80)
            send_item(REQ_DRAW, $urandom, $urandom_range(0, 1));
         else if (pick < 85)
            send_item(REQ_RESEED, $urandom, $urandom_range(0, 1));
         else if (pick < 88)
            send_item(REQ_UNUSED, $urandom, $urandom_range(0, 1));
         else if (pick < 93)
            // a key word left pending across draws
            send_item(REQ_KEY, $urandom, 1'b0);
         else
            send_key_run($urandom_range(1, 6));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // top extreme seeds the first draw, which must seed itself
      write_boot_seed(32'hffff_ffff);

      // directed part
      send_item(REQ_DRAW, 32'h0, 1'b1);
      send_item(REQ_DRAW, 32'hffff_ffff, 1'b0);
      send_item(REQ_UNUSED, 32'hffff_ffff, 1'b1);
      send_item(REQ_DRAW, 32'h0, 1'b0);
      send_item(REQ_RESEED, 32'h0, 1'b1);
      send_item(REQ_DRAW, 32'h0, 1'b0);
      send_item(REQ_RESEED, 32'hffff_ffff, 1'b0);
      send_item(REQ_DRAW, 32'hffff_ffff, 1'b1);
      send_item(REQ_KEY, 32'h0, 1'b1);
      send_item(REQ_DRAW, 32'h0, 1'b0);
      send_item(REQ_KEY, 32'hffff_ffff, 1'b1);
      send_item(REQ_DRAW, 32'h0, 1'b0);
      // key words pending across a reseed and a draw
      send_item(REQ_KEY, 32'h1234_5678, 1'b0);
      send_item(REQ_KEY, 32'hffff_ffff, 1'b0);
      send_item(REQ_RESEED, 32'd5489, 1'b0);
      send_item(REQ_DRAW, 32'h0, 1'b1);
      send_item(REQ_KEY, 32'h0, 1'b1);
      send_item(REQ_DRAW, 32'h0, 1'b0);
      send_item(REQ_DRAW, 32'hffff_ffff, 1'b1);
      settle();

      // random phases with a new register setting between them
      write_boot_seed(32'h0);
      random_phase(RANDOM_ITEMS / 3, 1'b1);
      settle();
      write_boot_seed($urandom);
      random_phase(RANDOM_ITEMS / 3, 1'b0);
      settle();
      write_boot_seed(32'hffff_ffff);
      random_phase(RANDOM_ITEMS / 3, 1'b1);
      settle();

      if (sb.mismatches == 0 && sb.draws_due.size() == 0)
         $display("mersenne_twister_generator_top_tb: clean");
      else
         $display("mersenne_twister_generator_top_tb: errors");
      $finish;
   end

endmodule
